// File: hw/rtl/tsam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_pkg: shared types and constants for touch sample averaging
// Field widths, register map, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsam_pkg;

    // Default burst length limit
    localparam int MAX_SAMPLES_DEF = 127;

    // Field widths
    localparam int RAW_W     = 13;
    localparam int AXIS_W    = 12;
    localparam int CAL_W     = 14;
    localparam int SIZE_W    = 12;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 7;

    // Shared divider: dividend and divisor widths
    localparam int DIV_W     = 26;
    localparam int DVS_W     = 14;

    // Stream and register port widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ORIENT       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAL_X_LEFT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAL_X_RIGHT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAL_Y_TOP    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAL_Y_BOTTOM = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_W     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_H     = 3'd7;

    // Orientation modes (the unused code behaves as native)
    localparam logic [MODE_W-1:0] MODE_NATIVE        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_PORTRAIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_LANDSCAPE = 2'd2;

    // Register reset values
    localparam logic [MODE_W-1:0]  RST_ORIENT       = MODE_NATIVE;
    localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 7'd10;
    localparam logic [CAL_W-1:0]   RST_CAL_LOW      = 14'd0;
    localparam logic [CAL_W-1:0]   RST_CAL_HIGH     = 14'd4095;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_W     = 12'd239;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_H     = 12'd319;

    typedef struct packed {
        logic [MODE_W-1:0]  orientation_mode;
        logic [COUNT_W-1:0] sample_count;
        logic [CAL_W-1:0]   cal_x_left;
        logic [CAL_W-1:0]   cal_x_right;
        logic [CAL_W-1:0]   cal_y_top;
        logic [CAL_W-1:0]   cal_y_bottom;
        logic [SIZE_W-1:0]  screen_width;
        logic [SIZE_W-1:0]  screen_height;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_LOAD,
        ST_AVG_RUN,
        ST_MAP_MUL,
        ST_MAP_LOAD,
        ST_MAP_RUN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accum;       // take one sampling slot
        logic div_start;   // launch both divider lanes
        logic div_map;     // divider operands: 0 averages, 1 screen map
        logic cap_avg;     // capture averages, apply orientation swap
        logic mul;         // register map products and signs
        logic load_out;    // fill output register, clear burst state
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic burst_end;   // the slot on the input closes the burst
        logic burst_ok;    // every slot of that burst counted
        logic div_done;    // divider lanes finished
    } sts_t;

endpackage

// File: hw/rtl/tsam_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_div: unsigned restoring divider
// Produces one quotient bit per cycle; the quotient holds after done until
// the next start.
// ----------------------------------------------------------------------------
module tsam_div #(
    parameter int NUM_W = tsam_pkg::DIV_W,
    parameter int DEN_W = tsam_pkg::DVS_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    logic [NUM_W-1:0]  quo_reg,  quo_next;
    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    partial;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        partial   = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (partial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? DEN_W'(partial - {1'b0, den_reg}) : partial[DEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: hw/rtl/tsam_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_datapath: slot accumulation, averaging and screen mapping
// Holds the burst counters and sums, two divider lanes shared between the
// averaging and the mapping phase, and the output payload register.
// ----------------------------------------------------------------------------
module tsam_datapath #(
    parameter int MAX_SAMPLES = tsam_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tsam_pkg::cfg_t                 cfg,
    input  logic [tsam_pkg::RAW_W-1:0]     raw_x,
    input  logic [tsam_pkg::RAW_W-1:0]     raw_y,
    input  logic                           pen_down,
    input  tsam_pkg::cmd_t                 cmd,
    output tsam_pkg::sts_t                 sts,
    output logic                           touch_valid,
    output logic [tsam_pkg::AXIS_W-1:0]    avg_first,
    output logic [tsam_pkg::AXIS_W-1:0]    avg_second,
    output logic [tsam_pkg::AXIS_W-1:0]    screen_x,
    output logic [tsam_pkg::AXIS_W-1:0]    screen_y
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (CNT_W > tsam_pkg::COUNT_W) ? CNT_W : tsam_pkg::COUNT_W;
    localparam int SUM_W  = tsam_pkg::AXIS_W + CNT_W;
    localparam int AX_W   = tsam_pkg::AXIS_W;
    localparam int CAL_W  = tsam_pkg::CAL_W;
    localparam int SIZE_W = tsam_pkg::SIZE_W;
    localparam int DIV_W  = tsam_pkg::DIV_W;
    localparam int DVS_W  = tsam_pkg::DVS_W;
    localparam int DIFF_W = CAL_W + 1;
    localparam int SGN_W  = DIV_W + 2;
    localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_SAMPLES);

    // Burst state
    logic [CNT_W-1:0] slot_reg,  slot_next;
    logic [CNT_W-1:0] valid_reg, valid_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic             ok_reg;

    // Slot evaluation
    logic [CMP_W-1:0] n_eff;
    logic [CNT_W-1:0] slot_inc;
    logic [CNT_W-1:0] valid_inc;
    logic             slot_good;

    // Averages after orientation swap
    logic [AX_W-1:0] first_reg, second_reg;
    logic            native;
    logic            mirror_x, mirror_y;

    // Map lanes: 0 is screen x, 1 is screen y
    logic [AX_W-1:0]   lane_v      [2];
    logic [CAL_W-1:0]  lane_lo     [2];
    logic [CAL_W-1:0]  lane_hi     [2];
    logic [SIZE_W-1:0] lane_size   [2];
    logic              lane_mirror [2];
    logic [DIFF_W-1:0] diff        [2];
    logic [DIFF_W-1:0] span        [2];
    logic [CAL_W-1:0]  diff_mag    [2];
    logic [CAL_W-1:0]  span_mag    [2];
    logic [DIV_W-1:0]  prod        [2];

    logic [DIV_W-1:0]  prod_reg    [2];
    logic [DVS_W-1:0]  span_reg    [2];
    logic              neg_reg     [2];
    logic              zero_reg    [2];
    logic              mirror_reg  [2];
    logic [SIZE_W-1:0] size_reg    [2];

    // Divider lanes
    logic [DIV_W-1:0] div_num [2];
    logic [DVS_W-1:0] div_den [2];
    logic [DIV_W-1:0] div_quo [2];
    logic             div_done [2];
    logic [AX_W-1:0]  coord   [2];

    // Finish one coordinate: sign, mirror, zero span and clamp to 0..size
    function automatic logic [AX_W-1:0] map_finish(
        input logic [DIV_W-1:0]  q,
        input logic              neg,
        input logic              mirror,
        input logic              zero,
        input logic [SIZE_W-1:0] size
    );
        logic [SGN_W-1:0] q_ext;
        logic [SGN_W-1:0] q_sgn;
        logic [SGN_W-1:0] s_ext;
        logic [SGN_W-1:0] c;
        logic [AX_W-1:0]  res;
        q_ext = SGN_W'(q);
        s_ext = SGN_W'(size);
        q_sgn = neg ? (~q_ext + 1'b1) : q_ext;
        c     = mirror ? (s_ext - q_sgn) : q_sgn;
        priority if (zero) begin
            res = '0;
        end else if (c[SGN_W-1]) begin
            res = '0;
        end else if (c > s_ext) begin
            res = size;
        end else begin
            res = c[AX_W-1:0];
        end
        return res;
    endfunction

    // Effective burst length: zero acts as one, capped at the limit
    always_comb begin
        priority if (cfg.sample_count == '0) begin
            n_eff = CMP_W'(1);
        end else if (CMP_W'(cfg.sample_count) > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = CMP_W'(cfg.sample_count);
        end
    end

    // Evaluate the slot on the input
    assign slot_good = pen_down
                    && (raw_x != '0) && !raw_x[tsam_pkg::RAW_W-1]
                    && (raw_y != '0) && !raw_y[tsam_pkg::RAW_W-1];
    assign slot_inc  = slot_reg + 1'b1;
    assign valid_inc = valid_reg + CNT_W'(slot_good);

    assign sts.burst_end = (CMP_W'(slot_inc) >= n_eff);
    assign sts.burst_ok  = (valid_inc == slot_inc);
    assign sts.div_done  = div_done[0];

    // Advance or clear the burst counters and sums
    always_comb begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        priority if (cmd.load_out) begin
            slot_next  = '0;
            valid_next = '0;
            sum_x_next = '0;
            sum_y_next = '0;
        end else if (cmd.accum) begin
            slot_next  = slot_inc;
            valid_next = valid_inc;
            if (slot_good) begin
                sum_x_next = sum_x_reg + SUM_W'(raw_x[AX_W-1:0]);
                sum_y_next = sum_y_reg + SUM_W'(raw_y[AX_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    // Orientation decode; the unused mode code behaves as native
    assign mirror_x = (cfg.orientation_mode == tsam_pkg::MODE_ROT_PORTRAIT);
    assign mirror_y = (cfg.orientation_mode == tsam_pkg::MODE_ROT_LANDSCAPE);
    assign native   = !mirror_x && !mirror_y;

    // Select window and size per lane
    always_comb begin
        lane_v[0]      = first_reg;
        lane_lo[0]     = native ? cfg.cal_x_left    : cfg.cal_y_top;
        lane_hi[0]     = native ? cfg.cal_x_right   : cfg.cal_y_bottom;
        lane_size[0]   = native ? cfg.screen_width  : cfg.screen_height;
        lane_mirror[0] = mirror_x;
        lane_v[1]      = second_reg;
        lane_lo[1]     = native ? cfg.cal_y_top     : cfg.cal_x_left;
        lane_hi[1]     = native ? cfg.cal_y_bottom  : cfg.cal_x_right;
        lane_size[1]   = native ? cfg.screen_height : cfg.screen_width;
        lane_mirror[1] = mirror_y;
    end

    // Offset, span and magnitude product per lane
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            diff[i]     = DIFF_W'(lane_v[i]) - DIFF_W'(lane_lo[i]);
            span[i]     = DIFF_W'(lane_hi[i]) - DIFF_W'(lane_lo[i]);
            diff_mag[i] = diff[i][DIFF_W-1] ? CAL_W'(~diff[i] + 1'b1) : diff[i][CAL_W-1:0];
            span_mag[i] = span[i][DIFF_W-1] ? CAL_W'(~span[i] + 1'b1) : span[i][CAL_W-1:0];
            prod[i]     = DIV_W'(diff_mag[i]) * DIV_W'(lane_size[i]);
        end
    end

    // Capture averages, burst status and map operands
    always_ff @(posedge aclk) begin
        if (cmd.cap_avg) begin
            first_reg  <= native ? div_quo[1][AX_W-1:0] : div_quo[0][AX_W-1:0];
            second_reg <= native ? div_quo[0][AX_W-1:0] : div_quo[1][AX_W-1:0];
        end
        if (cmd.accum && sts.burst_end) begin
            ok_reg <= sts.burst_ok;
        end
        for (int i = 0; i < 2; i++) begin
            if (cmd.mul) begin
                prod_reg[i]   <= prod[i];
                span_reg[i]   <= DVS_W'(span_mag[i]);
                neg_reg[i]    <= diff[i][DIFF_W-1] ^ span[i][DIFF_W-1];
                zero_reg[i]   <= (span[i] == '0);
                mirror_reg[i] <= lane_mirror[i];
                size_reg[i]   <= lane_size[i];
            end
        end
    end

    // Divider operands: sums by slot count, or map product by span
    always_comb begin
        div_num[0] = cmd.div_map ? prod_reg[0] : DIV_W'(sum_x_reg);
        div_num[1] = cmd.div_map ? prod_reg[1] : DIV_W'(sum_y_reg);
        div_den[0] = cmd.div_map ? span_reg[0] : DVS_W'(slot_reg);
        div_den[1] = cmd.div_map ? span_reg[1] : DVS_W'(slot_reg);
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        tsam_div #(
            .NUM_W (DIV_W),
            .DEN_W (DVS_W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (cmd.div_start),
            .dividend (div_num[g]),
            .divisor  (div_den[g]),
            .quotient (div_quo[g]),
            .done     (div_done[g])
        );

        assign coord[g] = map_finish(div_quo[g], neg_reg[g], mirror_reg[g],
                                     zero_reg[g], size_reg[g]);
    end

    // Output payload; an invalid burst reports zeros
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            touch_valid <= ok_reg;
            avg_first   <= ok_reg ? first_reg  : '0;
            avg_second  <= ok_reg ? second_reg : '0;
            screen_x    <= ok_reg ? coord[0]   : '0;
            screen_y    <= ok_reg ? coord[1]   : '0;
        end
    end

endmodule

// File: hw/rtl/tsam_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_ctrl: burst sequencer
// Accepts sampling slots, runs the averaging and mapping divisions at the end
// of a burst whose slots all counted, and owns the output valid flag.
// ----------------------------------------------------------------------------
module tsam_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  tsam_pkg::sts_t sts,
    output tsam_pkg::cmd_t cmd
);

    tsam_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // State register and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsam_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            tsam_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accum = 1'b1;
                    if (sts.burst_end) begin
                        state_next = sts.burst_ok ? tsam_pkg::ST_AVG_LOAD
                                                  : tsam_pkg::ST_FINISH;
                    end
                end
            end
            tsam_pkg::ST_AVG_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = tsam_pkg::ST_AVG_RUN;
            end
            tsam_pkg::ST_AVG_RUN: begin
                if (sts.div_done) begin
                    cmd.cap_avg = 1'b1;
                    state_next  = tsam_pkg::ST_MAP_MUL;
                end
            end
            tsam_pkg::ST_MAP_MUL: begin
                cmd.mul    = 1'b1;
                state_next = tsam_pkg::ST_MAP_LOAD;
            end
            tsam_pkg::ST_MAP_LOAD: begin
                cmd.div_start = 1'b1;
                cmd.div_map   = 1'b1;
                state_next    = tsam_pkg::ST_MAP_RUN;
            end
            tsam_pkg::ST_MAP_RUN: begin
                cmd.div_map = 1'b1;
                if (sts.div_done) begin
                    state_next = tsam_pkg::ST_FINISH;
                end
            end
            tsam_pkg::ST_FINISH: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = tsam_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsam_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: hw/rtl/touch_sample_average_and_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_average_and_map: resistive touch averaging and calibration
// Each input transaction is one sampling slot (raw X/Y pair and pen flag).
// After a burst of slots one result transaction carries the averages and the
// calibrated screen coordinates.
//
// Usage:
//   s_ channel: one transaction per slot; a slot that does not end a burst
//   is taken and the block stays ready for the next slot.
//   m_ channel: one transaction per burst; after the slot that ends the
//   burst the two divider lanes run the averages, then the screen map, and
//   the result is loaded into the output register, which raises m_tvalid;
//   a burst with an invalid slot goes straight to the load. s_tready is
//   low while the lanes run.
//   The output register lets the next burst fill while a result waits; a
//   burst that ends before the waiting result is taken holds in its last step
//   until m_tready frees the register.
//   Configuration goes through the register port while the block is idle.
//   Reset clears the burst counters and sums, drops m_tvalid and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module touch_sample_average_and_map #(
    parameter int MAX_SAMPLES = tsam_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Sampling slots
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsam_pkg::S_TDATA_W-1:0]  s_tdata,   // raw_x[12:0], raw_y[25:13]
    input  logic                            s_tuser,   // pen_down

    // Burst results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // avg_first[11:0], avg_second[23:12], screen_x[35:24], screen_y[47:36]
    output logic [tsam_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // touch_valid

    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsam_pkg::ADDR_W-1:0]     paddr,
    input  logic [tsam_pkg::DATA_W-1:0]     pwdata,
    output logic [tsam_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int RAW_W  = tsam_pkg::RAW_W;
    localparam int AX_W   = tsam_pkg::AXIS_W;
    localparam int DATA_W = tsam_pkg::DATA_W;

    tsam_pkg::cfg_t cfg_reg, cfg_next;
    tsam_pkg::cmd_t cmd;
    tsam_pkg::sts_t sts;

    logic [tsam_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           reg_wr;
    logic [AX_W-1:0]                avg_first, avg_second, screen_x, screen_y;

    // Register port: write on the access cycle, no wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[tsam_pkg::ADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (reg_wr) begin
            unique case (reg_idx)
                tsam_pkg::REG_ORIENT:
                    cfg_next.orientation_mode = pwdata[tsam_pkg::MODE_W-1:0];
                tsam_pkg::REG_SAMPLE_COUNT:
                    cfg_next.sample_count = pwdata[tsam_pkg::COUNT_W-1:0];
                tsam_pkg::REG_CAL_X_LEFT:
                    cfg_next.cal_x_left = pwdata[tsam_pkg::CAL_W-1:0];
                tsam_pkg::REG_CAL_X_RIGHT:
                    cfg_next.cal_x_right = pwdata[tsam_pkg::CAL_W-1:0];
                tsam_pkg::REG_CAL_Y_TOP:
                    cfg_next.cal_y_top = pwdata[tsam_pkg::CAL_W-1:0];
                tsam_pkg::REG_CAL_Y_BOTTOM:
                    cfg_next.cal_y_bottom = pwdata[tsam_pkg::CAL_W-1:0];
                tsam_pkg::REG_SCREEN_W:
                    cfg_next.screen_width = pwdata[tsam_pkg::SIZE_W-1:0];
                tsam_pkg::REG_SCREEN_H:
                    cfg_next.screen_height = pwdata[tsam_pkg::SIZE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.orientation_mode <= tsam_pkg::RST_ORIENT;
            cfg_reg.sample_count     <= tsam_pkg::RST_SAMPLE_COUNT;
            cfg_reg.cal_x_left       <= tsam_pkg::RST_CAL_LOW;
            cfg_reg.cal_x_right      <= tsam_pkg::RST_CAL_HIGH;
            cfg_reg.cal_y_top        <= tsam_pkg::RST_CAL_LOW;
            cfg_reg.cal_y_bottom     <= tsam_pkg::RST_CAL_HIGH;
            cfg_reg.screen_width     <= tsam_pkg::RST_SCREEN_W;
            cfg_reg.screen_height    <= tsam_pkg::RST_SCREEN_H;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            tsam_pkg::REG_ORIENT:       prdata = DATA_W'(cfg_reg.orientation_mode);
            tsam_pkg::REG_SAMPLE_COUNT: prdata = DATA_W'(cfg_reg.sample_count);
            tsam_pkg::REG_CAL_X_LEFT:   prdata = DATA_W'(cfg_reg.cal_x_left);
            tsam_pkg::REG_CAL_X_RIGHT:  prdata = DATA_W'(cfg_reg.cal_x_right);
            tsam_pkg::REG_CAL_Y_TOP:    prdata = DATA_W'(cfg_reg.cal_y_top);
            tsam_pkg::REG_CAL_Y_BOTTOM: prdata = DATA_W'(cfg_reg.cal_y_bottom);
            tsam_pkg::REG_SCREEN_W:     prdata = DATA_W'(cfg_reg.screen_width);
            tsam_pkg::REG_SCREEN_H:     prdata = DATA_W'(cfg_reg.screen_height);
        endcase
    end

    tsam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsam_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .raw_x       (s_tdata[RAW_W-1:0]),
        .raw_y       (s_tdata[2*RAW_W-1:RAW_W]),
        .pen_down    (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .touch_valid (m_tuser),
        .avg_first   (avg_first),
        .avg_second  (avg_second),
        .screen_x    (screen_x),
        .screen_y    (screen_y)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {screen_y, screen_x, avg_second, avg_first};

endmodule

// File: tb/sv/touch_sample_average_and_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_average_and_map_test: self-checking bench for touch averaging
// Drives sampling slots on the s_ stream, predicts each burst result from a
// shadow copy of the registers and burst state, and checks every m_ stream
// transaction field by field. Registers are rewritten through the APB port
// between phases while the block is idle. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module touch_sample_average_and_map_test;
    import tsam_pkg::*;

    localparam int          SLOT_LIMIT    = MAX_SAMPLES_DEF;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          RAW_VALID_MAX = 4095;
    localparam int          CAL_MAX       = 16383;
    localparam int          SIZE_MAX      = 4095;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic             pen_down;
        logic             drain;     // hold until all results are in
    } slot_t;

    typedef struct packed {
        logic              touch_valid;
        logic [AXIS_W-1:0] avg_first;
        logic [AXIS_W-1:0] avg_second;
        logic [AXIS_W-1:0] screen_x;
        logic [AXIS_W-1:0] screen_y;
    } touch_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;    // raw_x[12:0], raw_y[25:13]
    logic                  s_tuser = 1'b0;  // pen_down
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // avg_first[11:0], avg_second[23:12], screen_x[35:24], screen_y[47:36]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;         // touch_valid
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Shadow registers and burst state
    cfg_t        shadow_cfg = '{orientation_mode: RST_ORIENT, sample_count: RST_SAMPLE_COUNT,
                                cal_x_left: RST_CAL_LOW, cal_x_right: RST_CAL_HIGH,
                                cal_y_top: RST_CAL_LOW, cal_y_bottom: RST_CAL_HIGH,
                                screen_width: RST_SCREEN_W, screen_height: RST_SCREEN_H};
    int unsigned slots_taken = 0;
    int unsigned valid_slots = 0;
    int unsigned sum_x = 0;
    int unsigned sum_y = 0;

    slot_t       slot_q[$];
    touch_t      touch_exp_q[$];
    slot_t       next_slot;
    int          slots_in_flight = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    touch_sample_average_and_map uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (quiet || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // Linear calibration map, truncated toward zero and clamped to 0..size
    function automatic logic [AXIS_W-1:0] screen_map(int unsigned v, int unsigned lo,
                                                     int unsigned hi, int unsigned size,
                                                     bit mirror);
        longint span;
        longint scale;
        longint pos;
        span  = longint'(hi) - longint'(lo);
        scale = longint'(size);
        if (span == 0) return '0;
        pos = (longint'(v) - longint'(lo)) * (mirror ? -scale : scale) / span;
        if (mirror) pos = pos + scale;
        if (pos < 0) pos = 0;
        if (pos > scale) pos = scale;
        return pos[AXIS_W-1:0];
    endfunction

    // Accumulate one slot; close the burst and queue its result when due
    function automatic void accumulate_slot(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y,
                                            logic pen);
        int unsigned burst_len;
        int unsigned ax;
        int unsigned ay;
        logic [MODE_W-1:0] mode;
        touch_t res;
        burst_len = shadow_cfg.sample_count;
        if (burst_len == 0) burst_len = 1;
        if (burst_len > SLOT_LIMIT) burst_len = SLOT_LIMIT;
        if (pen && x != 0 && x <= RAW_VALID_MAX && y != 0 && y <= RAW_VALID_MAX) begin
            sum_x += x;
            sum_y += y;
            valid_slots++;
        end
        slots_taken++;
        if (slots_taken < burst_len) return;

        res = '0;
        if (valid_slots == slots_taken) begin
            ax = sum_x / slots_taken;
            ay = sum_y / slots_taken;
            mode = (shadow_cfg.orientation_mode == MODE_UNUSED) ? MODE_NATIVE
                                                                : shadow_cfg.orientation_mode;
            res.touch_valid = 1'b1;
            case (mode)
                MODE_NATIVE: begin
                    res.avg_first  = ay[AXIS_W-1:0];
                    res.avg_second = ax[AXIS_W-1:0];
                    res.screen_x   = screen_map(ay, shadow_cfg.cal_x_left,
                                                shadow_cfg.cal_x_right,
                                                shadow_cfg.screen_width, 1'b0);
                    res.screen_y   = screen_map(ax, shadow_cfg.cal_y_top,
                                                shadow_cfg.cal_y_bottom,
                                                shadow_cfg.screen_height, 1'b0);
                end
                MODE_ROT_PORTRAIT: begin
                    res.avg_first  = ax[AXIS_W-1:0];
                    res.avg_second = ay[AXIS_W-1:0];
                    res.screen_x   = screen_map(ax, shadow_cfg.cal_y_top,
                                                shadow_cfg.cal_y_bottom,
                                                shadow_cfg.screen_height, 1'b1);
                    res.screen_y   = screen_map(ay, shadow_cfg.cal_x_left,
                                                shadow_cfg.cal_x_right,
                                                shadow_cfg.screen_width, 1'b0);
                end
                default: begin
                    res.avg_first  = ax[AXIS_W-1:0];
                    res.avg_second = ay[AXIS_W-1:0];
                    res.screen_x   = screen_map(ax, shadow_cfg.cal_y_top,
                                                shadow_cfg.cal_y_bottom,
                                                shadow_cfg.screen_height, 1'b0);
                    res.screen_y   = screen_map(ay, shadow_cfg.cal_x_left,
                                                shadow_cfg.cal_x_right,
                                                shadow_cfg.screen_width, 1'b1);
                end
            endcase
        end
        touch_exp_q.push_back(res);
        slots_taken = 0;
        valid_slots = 0;
        sum_x = 0;
        sum_y = 0;
    endfunction

    task automatic report_mismatch(string field, logic [M_TDATA_W-1:0] got,
                                   logic [M_TDATA_W-1:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                 results_seen, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [M_TDATA_W-1:0] data, logic flag);
        touch_t want;
        if (touch_exp_q.size() == 0) begin
            report_mismatch("unexpected transaction", data, '0);
            return;
        end
        want = touch_exp_q.pop_front();
        if (flag !== want.touch_valid)
            report_mismatch("touch_valid", flag, want.touch_valid);
        if (data[11:0] !== want.avg_first)
            report_mismatch("avg_first", data[11:0], want.avg_first);
        if (data[23:12] !== want.avg_second)
            report_mismatch("avg_second", data[23:12], want.avg_second);
        if (data[35:24] !== want.screen_x)
            report_mismatch("screen_x", data[35:24], want.screen_x);
        if (data[47:36] !== want.screen_y)
            report_mismatch("screen_y", data[47:36], want.screen_y);
    endtask

    // Slot driver: issue queued slots with random gaps, honor drain holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (slot_q.size() != 0 &&
                         !(slot_q[0].drain && (s_tvalid || touch_exp_q.size() != 0))) begin
                next_slot = slot_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W - 2 * RAW_W){1'b0}}, next_slot.raw_y, next_slot.raw_x};
                s_tuser  <= next_slot.pen_down;
                gap_left <= idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check results, predict from accepted slots, stall the receiver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser);
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                accumulate_slot(s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W], s_tuser);
                slots_in_flight--;
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(4) == 0) begin
                stall_left <= idle_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apply_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_ORIENT:       shadow_cfg.orientation_mode = value[MODE_W-1:0];
            REG_SAMPLE_COUNT: shadow_cfg.sample_count     = value[COUNT_W-1:0];
            REG_CAL_X_LEFT:   shadow_cfg.cal_x_left       = value[CAL_W-1:0];
            REG_CAL_X_RIGHT:  shadow_cfg.cal_x_right      = value[CAL_W-1:0];
            REG_CAL_Y_TOP:    shadow_cfg.cal_y_top        = value[CAL_W-1:0];
            REG_CAL_Y_BOTTOM: shadow_cfg.cal_y_bottom     = value[CAL_W-1:0];
            REG_SCREEN_W:     shadow_cfg.screen_width     = value[SIZE_W-1:0];
            default:          shadow_cfg.screen_height    = value[SIZE_W-1:0];
        endcase
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, value);
    endtask

    // Wait until every slot is taken and every result is in, then settle
    task automatic wait_idle();
        while (slots_in_flight != 0 || touch_exp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_slot(int unsigned x, int unsigned y, bit pen, bit drain);
        slot_t s;
        s.raw_x    = x[RAW_W-1:0];
        s.raw_y    = y[RAW_W-1:0];
        s.pen_down = pen;
        s.drain    = drain;
        slot_q.push_back(s);
        slots_in_flight++;
    endtask

    task automatic queue_good_slot();
        queue_slot($urandom_range(1, RAW_VALID_MAX), $urandom_range(1, RAW_VALID_MAX),
                   1'b1, $urandom_range(59) == 0);
    endtask

    // A slot that spoils the burst (the fully random kind may still count)
    task automatic queue_bad_slot();
        case ($urandom_range(5))
            0: queue_slot($urandom_range(1, RAW_VALID_MAX), $urandom_range(1, RAW_VALID_MAX),
                          1'b0, 1'b0);
            1: queue_slot(0, $urandom_range(8191), 1'b1, 1'b0);
            2: queue_slot($urandom_range(8191), 0, 1'b1, 1'b0);
            3: queue_slot($urandom_range(4096, 8191), $urandom_range(8191), 1'b1, 1'b0);
            4: queue_slot($urandom_range(8191), $urandom_range(4096, 8191), 1'b1, 1'b0);
            default: queue_slot($urandom_range(8191), $urandom_range(8191),
                                $urandom_range(1), 1'b0);
        endcase
    endtask

    // Stray upper bits that the register must drop
    function automatic logic [DATA_W-1:0] junk(int w);
        logic [DATA_W-1:0] r;
        r = $urandom();
        return ($urandom_range(3) == 0) ? (r << w) : '0;
    endfunction

    // Calibration window: typical, reversed, near the data, wide, or zero span
    task automatic pick_window(output int unsigned lo, output int unsigned hi);
        int unsigned t;
        case ($urandom_range(5))
            0, 1: begin
                lo = $urandom_range(0, 500);
                hi = $urandom_range(3600, 4095);
            end
            2: begin
                hi = $urandom_range(0, 500);
                lo = $urandom_range(3600, 4095);
            end
            3: begin
                lo = $urandom_range(0, 4000);
                hi = lo + $urandom_range(1, 64);
            end
            4: begin
                lo = $urandom_range(CAL_MAX);
                hi = $urandom_range(CAL_MAX);
            end
            default: begin
                t  = $urandom_range(CAL_MAX);
                lo = t;
                hi = t;
            end
        endcase
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(7))
            0: return 0;
            1: return SIZE_MAX;
            default: return $urandom_range(1, SIZE_MAX);
        endcase
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0) return 0;
        if (r < 3) return $urandom_range(7, 24);
        return $urandom_range(1, 6);
    endfunction

    task automatic randomize_config(bit longest);
        int unsigned lo;
        int unsigned hi;
        write_reg(REG_ORIENT, $urandom_range(3) | junk(MODE_W));
        write_reg(REG_SAMPLE_COUNT, longest ? SLOT_LIMIT : pick_count());
        pick_window(lo, hi);
        write_reg(REG_CAL_X_LEFT, lo | junk(CAL_W));
        write_reg(REG_CAL_X_RIGHT, hi | junk(CAL_W));
        pick_window(lo, hi);
        write_reg(REG_CAL_Y_TOP, lo | junk(CAL_W));
        write_reg(REG_CAL_Y_BOTTOM, hi | junk(CAL_W));
        write_reg(REG_SCREEN_W, pick_size() | junk(SIZE_W));
        write_reg(REG_SCREEN_H, pick_size() | junk(SIZE_W));
    endtask

    // Stimulus sequence
    initial begin
        int unsigned burst_len;
        int unsigned bursts;
        int          bad_at;
        int          random_items;
        bit          longest;

        random_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: one full burst of ten clean slots
        @(negedge aclk);
        for (int i = 0; i < 10; i++) queue_good_slot();
        wait_idle();

        // Count zero acts as one, unused mode acts as native, zero Y span,
        // widest X window, screen size extremes; field extremes and each
        // way a slot can fail
        write_reg(REG_SAMPLE_COUNT, 0);
        write_reg(REG_ORIENT, MODE_UNUSED);
        write_reg(REG_CAL_X_LEFT, 0);
        write_reg(REG_CAL_X_RIGHT, CAL_MAX);
        write_reg(REG_CAL_Y_TOP, CAL_MAX);
        write_reg(REG_CAL_Y_BOTTOM, CAL_MAX);
        write_reg(REG_SCREEN_W, SIZE_MAX);
        write_reg(REG_SCREEN_H, 0);
        @(negedge aclk);
        queue_slot(1, 4095, 1'b1, 1'b0);
        queue_slot(4095, 1, 1'b1, 1'b0);
        queue_slot(0, 100, 1'b1, 1'b0);
        queue_slot(4096, 100, 1'b1, 1'b0);
        queue_slot(100, 0, 1'b1, 1'b0);
        queue_slot(100, 4096, 1'b1, 1'b0);
        queue_slot(8191, 8191, 1'b1, 1'b0);
        queue_slot(2000, 2000, 1'b0, 1'b0);
        wait_idle();

        // Portrait rotation with a reversed X window; lower the count mid-burst
        write_reg(REG_ORIENT, MODE_ROT_PORTRAIT);
        write_reg(REG_SAMPLE_COUNT, 8);
        write_reg(REG_CAL_X_LEFT, 4095);
        write_reg(REG_CAL_X_RIGHT, 0);
        write_reg(REG_CAL_Y_TOP, 0);
        write_reg(REG_CAL_Y_BOTTOM, 4095);
        write_reg(REG_SCREEN_W, 239);
        write_reg(REG_SCREEN_H, 319);
        @(negedge aclk);
        for (int i = 0; i < 5; i++) queue_good_slot();
        wait_idle();
        write_reg(REG_SAMPLE_COUNT, 3);
        @(negedge aclk);
        queue_slot(3000, 17, 1'b1, 1'b1);
        wait_idle();

        // Random phases: the first runs the longest burst
        longest = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            randomize_config(longest);
            burst_len = (shadow_cfg.sample_count == 0) ? 1 : shadow_cfg.sample_count;
            bursts    = longest ? 1 : $urandom_range(1, 5);
            quiet     = ($urandom_range(4) == 0);
            @(negedge aclk);
            for (int b = 0; b < bursts; b++) begin
                bad_at = ($urandom_range(4) == 0) ? int'($urandom_range(burst_len - 1)) : -1;
                for (int s = 0; s < burst_len; s++) begin
                    if (s == bad_at || $urandom_range(40) == 0) queue_bad_slot();
                    else queue_good_slot();
                    random_items++;
                end
            end
            // Leave a partial burst so the next settings start mid-burst
            if (burst_len > 1 && $urandom_range(3) == 0) begin
                for (int s = $urandom_range(1, burst_len - 1); s > 0; s--) begin
                    queue_good_slot();
                    random_items++;
                end
            end
            longest = 1'b0;
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: touch_sample_average_and_map.f
hw/rtl/tsam_pkg.sv
hw/rtl/tsam_div.sv
hw/rtl/tsam_datapath.sv
hw/rtl/tsam_ctrl.sv
hw/rtl/touch_sample_average_and_map.sv
tb/sv/touch_sample_average_and_map_test.sv
